FILE: rtl/core/gcipher_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcipher_pkg
// Shared types, constants and alphabet mapping functions for the cipher.
// ----------------------------------------------------------------------------
package gcipher_pkg;

  // Key geometry
  localparam int KEY_MAX   = 16;
  localparam int KEY_POS_W = $clog2(KEY_MAX);
  localparam int KEY_LEN_W = 5;
  localparam int DIGIT_W   = 4;
  localparam int KEYS_W    = 64;

  // Alphabet
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 8;
  localparam int ALPHA_SIZE = 211;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] REG_KEY_DIGITS = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Default queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } gcipher_lookup_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [DIGIT_W-1:0] digit;
  } gcipher_item_t;

  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_length;
    logic [KEYS_W-1:0]    key_digits;
  } gcipher_key_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gcipher_q_status_t;

  // Byte to alphabet index; hit is low for bytes outside the alphabet.
  function automatic gcipher_lookup_t gc_char_to_index(input logic [CHAR_W-1:0] b);
    gcipher_lookup_t r;
    r.hit = 1'b1;
    r.idx = '0;
    if (b >= 8'd65 && b <= 8'd90) begin
      r.idx = 8'(b - 8'd65);
    end else if (b >= 8'd97 && b <= 8'd122) begin
      r.idx = 8'(8'd26 + (b - 8'd97));
    end else if (b >= 8'd48 && b <= 8'd57) begin
      r.idx = 8'(8'd52 + (b - 8'd48));
    end else if (b >= 8'd123 && b <= 8'd190) begin
      r.idx = 8'(8'd62 + (b - 8'd123));
    end else if (b >= 8'd192) begin
      r.idx = 8'(8'd130 + (b - 8'd192));
    end else if (b >= 8'd32 && b <= 8'd47) begin
      r.idx = 8'(8'd194 + (b - 8'd32));
    end else if (b == 8'd63) begin
      r.idx = 8'd210;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Alphabet index (0..210) back to its byte.
  function automatic logic [CHAR_W-1:0] gc_index_to_char(input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] c;
    if (i < 8'd26) begin
      c = 8'(8'd65 + i);
    end else if (i < 8'd52) begin
      c = 8'(8'd97 + (i - 8'd26));
    end else if (i < 8'd62) begin
      c = 8'(8'd48 + (i - 8'd52));
    end else if (i < 8'd130) begin
      c = 8'(8'd123 + (i - 8'd62));
    end else if (i < 8'd194) begin
      c = 8'(8'd192 + (i - 8'd130));
    end else if (i < 8'd210) begin
      c = 8'(8'd32 + (i - 8'd194));
    end else begin
      c = 8'd63;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/gcipher_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcipher_front
// Classify input bytes, pick the key digit and advance the key position.
// ----------------------------------------------------------------------------
module gcipher_front import gcipher_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [CHAR_W-1:0]  in_char,
  input  logic               in_end_of_text,
  input  gcipher_key_cfg_t   key_cfg,
  output logic               push,
  output gcipher_item_t      push_item
);

  logic [KEY_POS_W-1:0] key_pos_r;
  logic [KEY_POS_W-1:0] key_pos_nxt;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] pos_inc;
  gcipher_lookup_t      lookup;

  assign lookup = gc_char_to_index(in_char);

  // Zero length acts as one, lengths above the maximum saturate.
  always_comb begin
    if (key_cfg.key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_cfg.key_length > KEY_LEN_W'(KEY_MAX)) begin
      eff_len = KEY_LEN_W'(KEY_MAX);
    end else begin
      eff_len = key_cfg.key_length;
    end
  end

  assign pos_inc = KEY_LEN_W'({1'b0, key_pos_r}) + KEY_LEN_W'(1);

  always_comb begin
    key_pos_nxt = key_pos_r;
    if (accept) begin
      if (lookup.hit) begin
        if (pos_inc >= eff_len) begin
          key_pos_nxt = '0;
        end else begin
          key_pos_nxt = pos_inc[KEY_POS_W-1:0];
        end
      end
      if (in_end_of_text) begin
        key_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
    end else begin
      key_pos_r <= key_pos_nxt;
    end
  end

  assign push            = accept && lookup.hit;
  assign push_item.idx   = lookup.idx;
  assign push_item.digit = key_cfg.key_digits[key_pos_r*DIGIT_W +: DIGIT_W];

endmodule

FILE: rtl/core/gcipher_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcipher_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module gcipher_queue import gcipher_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gcipher_item_t     push_item,
  input  logic              pop,
  output gcipher_item_t     head_item,
  output gcipher_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gcipher_item_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule

FILE: rtl/core/gcipher_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcipher_back
// Shift the alphabet index by the key digit and register the result byte.
// ----------------------------------------------------------------------------
module gcipher_back import gcipher_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mode,
  input  gcipher_item_t     head_item,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char
);

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [IDX_W:0]    sum;
  logic [IDX_W:0]    diff;
  logic [IDX_W-1:0]  shifted;

  assign sum  = {1'b0, head_item.idx} + (IDX_W+1)'(head_item.digit);
  assign diff = {1'b0, head_item.idx} - (IDX_W+1)'(head_item.digit);

  // One conditional correction brings the index back into 0..210.
  always_comb begin
    if (mode == MODE_DECRYPT) begin
      shifted = diff[IDX_W] ? IDX_W'(diff + (IDX_W+1)'(ALPHA_SIZE)) : diff[IDX_W-1:0];
    end else begin
      shifted = (sum >= (IDX_W+1)'(ALPHA_SIZE)) ?
                IDX_W'(sum - (IDX_W+1)'(ALPHA_SIZE)) : sum[IDX_W-1:0];
    end
  end

  assign pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_char_r <= gc_index_to_char(shifted);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

endmodule

FILE: rtl/core/gronsfeld_cipher_custom_alphabet.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gronsfeld_cipher_custom_alphabet
// Gronsfeld stream cipher over a fixed 211-symbol byte alphabet.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  in_char, in_end_of_text
//  result    out        out_valid/out_stall  out_char
//  config    in         APB (psel..pready)   paddr, pwdata, prdata
//
//  One transaction is taken per cycle while in_stall is low; a byte in the
//  alphabet gives its result through the queue write, then the output register.
//  Bytes outside the alphabet give no result but still honor end of text.
//  in_stall rises only when the front/back queue is full, which happens
//  only after out_stall has held the output register.
//  Reset clears the key position, the queue, the output valid and all
//  configuration registers (mode encrypt, key length 1, key digits 0).
//
module gronsfeld_cipher_custom_alphabet import gcipher_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_end_of_text,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_char,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers; registers sit on 8-byte boundaries
  logic                 mode_r;
  logic [KEY_LEN_W-1:0] key_length_r;
  logic [KEYS_W-1:0]    key_digits_r;
  logic [1:0]           reg_sel;
  logic                 cfg_wr;

  gcipher_key_cfg_t     key_cfg;
  gcipher_item_t        push_item;
  gcipher_item_t        head_item;
  gcipher_q_status_t    q_status;
  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 in_hit;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write registers; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ENCRYPT;
      key_length_r <= KEY_LEN_W'(1);
      key_digits_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODE:       mode_r       <= pwdata[0];
        REG_KEY_LENGTH: key_length_r <= pwdata[KEY_LEN_W-1:0];
        REG_KEY_DIGITS: key_digits_r <= pwdata[KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (reg_sel)
      REG_MODE:       prdata = CFG_DATA_W'(mode_r);
      REG_KEY_LENGTH: prdata = CFG_DATA_W'(key_length_r);
      REG_KEY_DIGITS: prdata = CFG_DATA_W'(key_digits_r);
      default:        prdata = '0;
    endcase
  end

  assign key_cfg.key_length = key_length_r;
  assign key_cfg.key_digits = key_digits_r;

  // Hold the input off only while the queue is full.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Front: classify the byte, pick its key digit, advance the key position.
  gcipher_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_char        (in_char),
    .in_end_of_text (in_end_of_text),
    .key_cfg        (key_cfg),
    .push           (push),
    .push_item      (push_item)
  );

  // Queue: decouple classification from the shift and output stage.
  gcipher_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Back: modular shift, index-to-byte mapping, output register.
  gcipher_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .head_item (head_item),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char)
  );

  // Independent membership check for the assertions below
  gcipher_lookup_t chk_lookup;
  assign chk_lookup = gc_char_to_index(in_char);
  assign in_hit     = chk_lookup.hit;

  // An accepted byte enters the queue exactly when it is in the alphabet.
  a_push_matches_hit: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (push == in_hit))
    else $error("queue push does not match alphabet membership");

  // A pushed item leaves the queue non-empty on the next cycle.
  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_status.empty)
    else $error("queue empty right after a push");

  // A result appears only from an item that was waiting in the queue.
  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!q_status.empty))
    else $error("result raised without a queued item");

  // The queue is only full after the output side has been stalled.
  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> $past(out_stall))
    else $error("queue full although output was not stalled");

endmodule
